FILE: design/mm2sh_pkg.sv
package mm2sh_pkg;

  // Hash constants
  localparam logic [31:0] MH_MUL       = 32'h5bd1e995;
  localparam int          MIX_SHIFT    = 24;
  localparam int          FIN_SHIFT_A  = 13;
  localparam int          FIN_SHIFT_B  = 15;

  // Datapath operations, one per cycle on the shared multiplier when not stalled
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MIX1,
    OP_MIX2,
    OP_FOLD,
    OP_TAIL,
    OP_FINAL
  } op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  // Classification of the item on the input ports
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } status_t;

endpackage

FILE: design/mm2sh_datapath.sv
module mm2sh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                hash_seed_we,
  input  logic [31:0]         hash_seed,
  input  logic [31:0]         key_word,
  input  logic [2:0]          valid_bytes,
  input  logic                first_word,
  input  logic                last_word,
  input  logic [31:0]         key_length,
  input  mm2sh_pkg::cmd_t     cmd,
  output mm2sh_pkg::status_t  status,
  output logic [31:0]         hash_value
);

  logic [31:0] seed;
  logic [31:0] acc;
  logic [31:0] tmp;
  logic [31:0] word_q;
  logic [1:0]  tail_len;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  // Classify the incoming item
  assign status.full  = valid_bytes[2];
  assign status.empty = (valid_bytes == 3'd0);
  assign status.last  = last_word;

  // Mask of the valid tail bytes
  always_comb begin
    case (tail_len)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  // Select the multiplier operand for the current operation
  always_comb begin
    case (cmd.op)
      mm2sh_pkg::OP_MIX1:  mul_a = word_q;
      mm2sh_pkg::OP_MIX2:  mul_a = tmp ^ (tmp >> mm2sh_pkg::MIX_SHIFT);
      mm2sh_pkg::OP_FOLD:  mul_a = acc;
      mm2sh_pkg::OP_TAIL:  mul_a = acc ^ (word_q & tail_mask);
      mm2sh_pkg::OP_FINAL: mul_a = acc ^ (acc >> mm2sh_pkg::FIN_SHIFT_A);
      default:             mul_a = 32'd0;
    endcase
  end

  assign prod = mul_a * mm2sh_pkg::MH_MUL;

  // Seed register and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
      acc  <= 32'd0;
    end else begin
      if (hash_seed_we) begin
        seed <= hash_seed;
      end
      if (cmd.load && first_word) begin
        acc <= seed ^ key_length;
      end else if (cmd.op == mm2sh_pkg::OP_FOLD) begin
        acc <= prod ^ tmp;
      end else if (cmd.op == mm2sh_pkg::OP_TAIL) begin
        acc <= prod;
      end
    end
  end

  // Item capture, mixed word and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_q   <= key_word;
      tail_len <= valid_bytes[1:0];
    end
    if (cmd.op == mm2sh_pkg::OP_MIX1 || cmd.op == mm2sh_pkg::OP_MIX2) begin
      tmp <= prod;
    end
    if (cmd.op == mm2sh_pkg::OP_FINAL) begin
      hash_value <= prod ^ (prod >> mm2sh_pkg::FIN_SHIFT_B);
    end
  end

endmodule

FILE: design/mm2sh_ctrl.sv
module mm2sh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mm2sh_pkg::status_t  status,
  output mm2sh_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_FOLD,
    S_TAIL,
    S_FINAL
  } state_t;

  state_t state;
  logic   last_q;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Issue one datapath operation per state
  always_comb begin
    cmd.load = accept;
    unique case (state)
      S_MIX1:  cmd.op = mm2sh_pkg::OP_MIX1;
      S_MIX2:  cmd.op = mm2sh_pkg::OP_MIX2;
      S_FOLD:  cmd.op = mm2sh_pkg::OP_FOLD;
      S_TAIL:  cmd.op = mm2sh_pkg::OP_TAIL;
      S_FINAL: cmd.op = out_free ? mm2sh_pkg::OP_FINAL : mm2sh_pkg::OP_NONE;
      default: cmd.op = mm2sh_pkg::OP_NONE;
    endcase
  end

  // Sequence the item and hold the result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result flag on finalize, drop it once the item is taken
      if (state == S_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state) inside
        S_IDLE: begin
          if (accept) begin
            last_q <= status.last;
            if (status.full) begin
              state <= S_MIX1;
            end else if (!status.empty) begin
              state <= S_TAIL;
            end else if (status.last) begin
              state <= S_FINAL;
            end
          end
        end
        S_MIX1: state <= S_MIX2;
        S_MIX2: state <= S_FOLD;
        S_FOLD, S_TAIL: state <= last_q ? S_FINAL : S_IDLE;
        S_FINAL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A waiting result is never overwritten
  a_final_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mm2sh_pkg::OP_FINAL) |-> out_free)
    else $error("finalize issued while result still waiting");

  // A blocked finalize stays in place
  a_final_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && !out_free) |=> (state == S_FINAL && out_valid))
    else $error("finalize left while output blocked");

  // A full word runs the mixing sequence
  a_full_mix: assert property (@(posedge clk) disable iff (rst)
    (accept && status.full) |=> (state == S_MIX1) ##1 (state == S_MIX2) ##1 (state == S_FOLD))
    else $error("full word did not run mix sequence");

  // A result appears only after finalize
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINAL))
    else $error("result raised outside finalize");

endmodule

FILE: design/murmur2_string_hash_top.sv
// MurmurHash2 (32-bit) stream hasher. Keys arrive as little-endian 32-bit words on the
// in_valid/in_ready channel; a word with first_word set restarts the accumulator at
// hash_seed XOR key_length, and a word with last_word set produces one hash_value on the
// out_valid/out_ready channel. One 32x32 multiplier is shared by every step, one product
// per cycle when not stalled: a word of 4 or more bytes runs accept, two mix products and
// fold, one of 1 to 3 bytes accept and a tail product, an empty one only accept, and a
// last word adds a finalize. The result sits in an output register, and the next word is
// taken while it waits; a finalize stalls only if the previous result has not been taken.
// hash_seed is written through hash_seed_we and should change only between keys.
module murmur2_string_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        hash_seed_we,
  input  logic [31:0] hash_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] key_word,
  input  logic [2:0]  valid_bytes,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] key_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  mm2sh_pkg::cmd_t    cmd;
  mm2sh_pkg::status_t status;

  mm2sh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mm2sh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .hash_seed_we (hash_seed_we),
    .hash_seed    (hash_seed),
    .key_word     (key_word),
    .valid_bytes  (valid_bytes),
    .first_word   (first_word),
    .last_word    (last_word),
    .key_length   (key_length),
    .cmd          (cmd),
    .status       (status),
    .hash_value   (hash_value)
  );

endmodule

FILE: verif/testbench.sv
module testbench;

  localparam logic [31:0] HASH_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT    = 24;
  localparam int          FIN_SHIFT_A  = 13;
  localparam int          FIN_SHIFT_B  = 15;
  localparam int          WORDS_PER_PHASE = 200;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        first;
    logic        last;
    logic [31:0] klen;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        hash_seed_we = 1'b0;
  logic [31:0] hash_seed = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] key_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        first_word = 1'b0;
  logic        last_word = 1'b0;
  logic [31:0] key_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_value;

  // Predictor state and bookkeeping
  key_word_t   word_queue[$];
  key_word_t   offered_word;
  logic [31:0] expected_hashes[$];
  logic [31:0] seed_copy = '0;
  logic [31:0] running_hash = '0;
  int          words_queued = 0;
  int          words_taken = 0;
  int          hash_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;

  murmur2_string_hash_top uut (
    .clk          (clk),
    .rst          (rst),
    .hash_seed_we (hash_seed_we),
    .hash_seed    (hash_seed),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_word     (key_word),
    .valid_bytes  (valid_bytes),
    .first_word   (first_word),
    .last_word    (last_word),
    .key_length   (key_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hash_value   (hash_value)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] murmur_mix(logic [31:0] k);
    k = k * HASH_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * HASH_MUL;
    return k;
  endfunction

  function automatic logic [31:0] murmur_finish(logic [31:0] h);
    h = h ^ (h >> FIN_SHIFT_A);
    h = h * HASH_MUL;
    h = h ^ (h >> FIN_SHIFT_B);
    return h;
  endfunction

  // Fold one accepted item into the running hash; queue the hash on a last word
  task automatic absorb_word(key_word_t it);
    logic [31:0] tail_mask;
    if (it.first) running_hash = seed_copy ^ it.klen;
    if (it.nbytes >= 3'd4) begin
      running_hash = (running_hash * HASH_MUL) ^ murmur_mix(it.word);
    end else if (it.nbytes != 3'd0) begin
      tail_mask = (32'd1 << (8 * it.nbytes)) - 32'd1;
      running_hash = running_hash ^ (it.word & tail_mask);
      running_hash = running_hash * HASH_MUL;
    end
    if (it.last) expected_hashes.push_back(murmur_finish(running_hash));
  endtask

  task automatic push_word(logic [31:0] word, logic [2:0] nbytes, logic first,
                           logic last, logic [31:0] klen);
    key_word_t it;
    it.word   = word;
    it.nbytes = nbytes;
    it.first  = first;
    it.last   = last;
    it.klen   = klen;
    word_queue.push_back(it);
    words_queued++;
  endtask

  // Split a key into words; garbage sits above the valid bytes of the tail
  task automatic queue_key(int unsigned key_bytes, logic [31:0] len_field,
                           bit empty_tail);
    int unsigned left;
    int unsigned take;
    logic [2:0]  nb;
    logic        first;
    left  = key_bytes;
    first = 1'b1;
    do begin
      take = (left >= 4) ? 4 : left;
      nb   = 3'(take);
      if (take == 4 && $urandom_range(99) < 10) nb = 3'($urandom_range(7, 5));
      left = left - take;
      push_word($urandom, nb, first, (left == 0) && !empty_tail,
                first ? len_field : $urandom);
      first = 1'b0;
    end while (left != 0);
    if (empty_tail) push_word($urandom, 3'd0, 1'b0, 1'b1, $urandom);
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    hash_seed_we <= 1'b1;
    hash_seed    <= value;
    seed_copy     = value;
    @(posedge clk);
    hash_seed_we <= 1'b0;
  endtask

  // Drive items from the queue, predicting each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(offered_word);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word = word_queue.pop_front();
          in_valid    <= 1'b1;
          key_word    <= offered_word.word;
          valid_bytes <= offered_word.nbytes;
          first_word  <= offered_word.first;
          last_word   <= offered_word.last;
          key_length  <= offered_word.klen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Accept results and compare against the oldest predicted hash
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          hash_errors++;
          if (hash_errors <= MAX_REPORTS)
            $display("unexpected hash_value %08h", hash_value);
        end else if (hash_value !== expected_hashes[0]) begin
          hash_errors++;
          if (hash_errors <= MAX_REPORTS)
            $display("hash_value mismatch: expected %08h, got %08h",
                     expected_hashes[0], hash_value);
          void'(expected_hashes.pop_front());
        end else begin
          void'(expected_hashes.pop_front());
        end
      end
      out_ready <= !(hold_req || hold_left != 0) &&
                   ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned key_bytes;
    logic [31:0] len_field;
    int          pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Words before any first word continue from the reset accumulator
    push_word(32'hffffffff, 3'd4, 1'b0, 1'b1, 32'h0);
    push_word(32'h0, 3'd3, 1'b0, 1'b1, 32'hffffffff);
    // Empty keys, extreme lengths
    push_word(32'h12345678, 3'd0, 1'b1, 1'b1, 32'h0);
    push_word(32'hffffffff, 3'd0, 1'b1, 1'b1, 32'hffffffff);
    // One-word keys with 1, 2 and 3 tail bytes, garbage above
    push_word(32'hffffffff, 3'd1, 1'b1, 1'b1, 32'd1);
    push_word(32'hffffffff, 3'd2, 1'b1, 1'b1, 32'd2);
    push_word(32'hffffffff, 3'd3, 1'b1, 1'b1, 32'd3);
    // Full words, including byte counts above four
    push_word(32'h0, 3'd4, 1'b1, 1'b1, 32'd4);
    push_word(32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4);
    push_word(32'hffffffff, 3'd5, 1'b1, 1'b1, 32'd4);
    push_word(32'h0, 3'd6, 1'b1, 1'b1, 32'd4);
    push_word(32'ha5a5a5a5, 3'd7, 1'b1, 1'b1, 32'd4);
    // Short word not marked last, then the key goes on
    push_word(32'hdeadbeef, 3'd2, 1'b1, 1'b0, 32'd7);
    push_word(32'h01020304, 3'd4, 1'b0, 1'b0, 32'h0);
    push_word(32'hffffff80, 3'd1, 1'b0, 1'b1, 32'h0);
    // Length that does not match the bytes sent
    push_word(32'hcafef00d, 3'd4, 1'b1, 1'b1, 32'd100);
    // Continue after an emitted hash, then an empty tail word ending a key
    push_word(32'h00ffffff, 3'd3, 1'b0, 1'b1, 32'h55555555);
    push_word(32'h87654321, 3'd4, 1'b1, 1'b0, 32'd4);
    push_word(32'hffffffff, 3'd0, 1'b0, 1'b1, 32'hffffffff);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  write_seed(32'hffffffff);
        end
        1: begin
          send_idle_pct = 56; recv_stall_pct = 0;  write_seed(32'h0);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 56; write_seed($urandom);
        end
        default: begin
          send_idle_pct = 14; recv_stall_pct = 14; write_seed($urandom);
        end
      endcase

      // Mostly well-formed keys, some stray words
      while (word_queue.size() < WORDS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          pick = $urandom_range(99);
          if (pick < 80)      key_bytes = $urandom_range(12);
          else if (pick < 95) key_bytes = $urandom_range(40, 13);
          else                key_bytes = $urandom_range(64, 41);
          len_field = ($urandom_range(99) < 90) ? key_bytes : $urandom;
          queue_key(key_bytes, len_field, $urandom_range(99) < 15);
        end else begin
          push_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom);
        end
      end

      // Stall the receiver long enough for the block to back up
      if (phase == 0) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_idle();
    end

    if (hash_errors == 0 && expected_hashes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
